@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the sync/length/CRC frame receiver: register
// indices, result kinds and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_SYNC_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SYNC_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CRC_INIT  = 2'd2;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CNT_MAX  = 16'hFFFF;

  typedef enum logic [1:0] {
    EVT_DATA      = 2'd0,
    EVT_EMPTY     = 2'd1,
    EVT_CRC_ERR   = 2'd2,
    EVT_SYNC_LOSS = 2'd3
  } evt_e;

  typedef enum logic [1:0] {
    CRC_HOLD,
    CRC_SEED,
    CRC_HELD,
    CRC_RX
  } crc_op_e;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_CLR,
    POS_INC
  } pos_op_e;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_EVT,
    OUT_DATA
  } out_op_e;

  typedef struct packed {
    crc_op_e crc_op;
    pos_op_e pos_op;
    out_op_e out_op;
    evt_e    evt_kind;
    logic    hold_byte;
    logic    clr_id;
    logic    take_id;
    logic    take_len;
    logic    wr_data;
    logic    take_crc_lo;
    logic    rd_issue;
    logic    inc_loss;
    logic    inc_crc_err;
  } cmd_t;

  typedef struct packed {
    logic hi_match;
    logic lo_match;
    logic rx_len_bad;
    logic rx_zero;
    logic len_zero;
    logic pos_last;
    logic crc_ok;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/sfr_ifs.sv @@
// ----------------------------------------------------------------------------
// sfr_ifs
// Channel interfaces of the frame receiver: received bytes, results and
// register writes, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, rx_byte, input ready);
  modport sink (input valid, rx_byte, output ready);
endinterface

interface sfr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  frame_id;
  logic [5:0]  frame_length;
  logic [7:0]  payload_byte;
  logic [5:0]  byte_position;
  logic        last_of_run;
  logic [15:0] sync_loss_total;
  logic [15:0] crc_error_total;

  modport source (output valid, event_kind, frame_id, frame_length, payload_byte,
                  byte_position, last_of_run, sync_loss_total, crc_error_total,
                  input ready);
  modport sink (input valid, event_kind, frame_id, frame_length, payload_byte,
                byte_position, last_of_run, sync_loss_total, crc_error_total,
                output ready);
endinterface

interface sfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

@@ rtl/sync_length_crc_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// sync_length_crc_frame_receiver
// Deframer for sync/id/length/payload/CRC-16 frames arriving one byte a beat.
// ----------------------------------------------------------------------------
// Usage: bytes enter on rx_i, one per beat. The block hunts for the two sync
// bytes, reads id and length, stores the payload and checks the little-endian
// CRC-16 (polynomial 0x1021) that covers sync, header and payload.
// Results leave on res_o: a good frame gives one beat per payload byte, the
// last one marked; an empty frame, a CRC mismatch or a sync loss gives a
// single beat. Registers are written on cfg_i (always ready); the user is to
// write them only while idle, which the block itself does not enforce.
// Rate: one byte is taken per cycle, except in the seed step after the second
// sync byte, since seeding the CRC needs two byte updates of the single CRC
// unit, and while results are sent. A single-beat result passes ST_EVENT into
// the output register; a payload byte passes the registered read port first.
// Reset puts the block in the sync hunt with the default registers and zeroed
// error counters. When the receiver stalls, the output register holds its
// beat; bytes keep being taken until a further result has to be produced.
// ----------------------------------------------------------------------------
module sync_length_crc_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 63
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfr_rx_if.sink    rx_i,
  sfr_res_if.source res_o,
  sfr_cfg_if.sink   cfg_i
);
  import sfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .rx_byte_i         (rx_i.rx_byte),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_index_i       (cfg_i.reg_index),
    .cfg_data_i        (cfg_i.wr_data),
    .res_ready_i       (res_o.ready),
    .res_valid_o       (res_o.valid),
    .event_kind_o      (res_o.event_kind),
    .frame_id_o        (res_o.frame_id),
    .frame_length_o    (res_o.frame_length),
    .payload_byte_o    (res_o.payload_byte),
    .byte_position_o   (res_o.byte_position),
    .last_of_run_o     (res_o.last_of_run),
    .sync_loss_total_o (res_o.sync_loss_total),
    .crc_error_total_o (res_o.crc_error_total)
  );

endmodule

@@ rtl/sfr_datapath.sv @@
// ----------------------------------------------------------------------------
// sfr_datapath
// Configuration registers, CRC register, header fields, payload store, error
// counters and the output register of the frame receiver.
// ----------------------------------------------------------------------------
module sfr_datapath #(
  parameter int unsigned MAX_PAYLOAD = 63
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sfr_pkg::cmd_t                 cmd_i,
  output sfr_pkg::sts_t                 sts_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          cfg_valid_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sfr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output logic [1:0]                    event_kind_o,
  output logic [7:0]                    frame_id_o,
  output logic [5:0]                    frame_length_o,
  output logic [7:0]                    payload_byte_o,
  output logic [5:0]                    byte_position_o,
  output logic                          last_of_run_o,
  output logic [15:0]                   sync_loss_total_o,
  output logic [15:0]                   crc_error_total_o
);
  import sfr_pkg::*;

  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // One byte into the CRC, MSB first: eight shift steps on a 16-bit value.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  logic [7:0]  sync_hi_q, sync_lo_q;
  logic [15:0] crc_init_q;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  byte_q;
  logic [7:0]  id_q;
  logic [5:0]  len_q;
  logic [5:0]  pos_q, pos_d;
  logic [7:0]  crc_lo_q;
  logic [15:0] loss_cnt_q, crc_cnt_q;
  logic [7:0]  mem_q [MAX_PAYLOAD];
  logic [7:0]  rd_data_q;
  logic [6:0]  pos_next;

  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [7:0]  out_id_q;
  logic [5:0]  out_len_q;
  logic [7:0]  out_data_q;
  logic [5:0]  out_pos_q;
  logic        out_last_q;
  logic [15:0] out_loss_q, out_crc_q;
  logic        out_free;

  assign pos_next = {1'b0, pos_q} + 7'd1;
  assign out_free = !out_valid_q || res_ready_i;

  assign sts_o.hi_match   = (rx_byte_i == sync_hi_q);
  assign sts_o.lo_match   = (rx_byte_i == sync_lo_q);
  assign sts_o.rx_len_bad = (rx_byte_i > 8'(MAX_PAYLOAD));
  assign sts_o.rx_zero    = (rx_byte_i == 8'd0);
  assign sts_o.len_zero   = (len_q == 6'd0);
  assign sts_o.pos_last   = (pos_next >= {1'b0, len_q});
  assign sts_o.crc_ok     = ({rx_byte_i, crc_lo_q} == crc_q);
  assign sts_o.out_free   = out_free;

  always_comb begin
    case (cmd_i.crc_op)
      CRC_SEED: crc_d = crc_feed(crc_init_q, sync_hi_q);
      CRC_HELD: crc_d = crc_feed(crc_q, byte_q);
      CRC_RX:   crc_d = crc_feed(crc_q, rx_byte_i);
      default:  crc_d = crc_q;
    endcase
  end

  always_comb begin
    case (cmd_i.pos_op)
      POS_CLR: pos_d = 6'd0;
      POS_INC: pos_d = pos_next[5:0];
      default: pos_d = pos_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_hi_q   <= 8'hAA;
      sync_lo_q   <= 8'h55;
      crc_init_q  <= 16'hFFFF;
      crc_q       <= '0;
      id_q        <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      crc_lo_q    <= '0;
      loss_cnt_q  <= '0;
      crc_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SYNC_HIGH: sync_hi_q  <= cfg_data_i[7:0];
          REG_SYNC_LOW:  sync_lo_q  <= cfg_data_i[7:0];
          REG_CRC_INIT:  crc_init_q <= cfg_data_i;
          default: ;
        endcase
      end
      crc_q <= crc_d;
      pos_q <= pos_d;
      if (cmd_i.clr_id) begin
        id_q <= '0;
      end else if (cmd_i.take_id) begin
        id_q <= rx_byte_i;
      end
      if (cmd_i.take_len) begin
        len_q <= rx_byte_i[5:0];
      end
      if (cmd_i.take_crc_lo) begin
        crc_lo_q <= rx_byte_i;
      end
      if (cmd_i.inc_loss && loss_cnt_q != CNT_MAX) begin
        loss_cnt_q <= loss_cnt_q + 16'd1;
      end
      if (cmd_i.inc_crc_err && crc_cnt_q != CNT_MAX) begin
        crc_cnt_q <= crc_cnt_q + 16'd1;
      end
      if (cmd_i.out_op != OUT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload store and its registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_byte) begin
      byte_q <= rx_byte_i;
    end
    if (cmd_i.wr_data) begin
      mem_q[pos_q[AddrW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[pos_q[AddrW-1:0]];
    end
  end

  // Output register payload; the counters are sampled as the result is loaded.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_op == OUT_EVT) begin
      out_kind_q <= cmd_i.evt_kind;
      out_id_q   <= id_q;
      out_len_q  <= '0;
      out_data_q <= '0;
      out_pos_q  <= '0;
      out_last_q <= 1'b1;
      out_loss_q <= loss_cnt_q;
      out_crc_q  <= crc_cnt_q;
    end else if (cmd_i.out_op == OUT_DATA) begin
      out_kind_q <= EVT_DATA;
      out_id_q   <= id_q;
      out_len_q  <= len_q;
      out_data_q <= rd_data_q;
      out_pos_q  <= pos_q;
      out_last_q <= sts_o.pos_last;
      out_loss_q <= loss_cnt_q;
      out_crc_q  <= crc_cnt_q;
    end
  end

  assign res_valid_o       = out_valid_q;
  assign event_kind_o      = out_kind_q;
  assign frame_id_o        = out_id_q;
  assign frame_length_o    = out_len_q;
  assign payload_byte_o    = out_data_q;
  assign byte_position_o   = out_pos_q;
  assign last_of_run_o     = out_last_q;
  assign sync_loss_total_o = out_loss_q;
  assign crc_error_total_o = out_crc_q;

endmodule

@@ rtl/sfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfr_ctrl
// Receive-phase state machine of the frame receiver. Decides per accepted
// byte what the datapath does, and sequences event and payload results.
// ----------------------------------------------------------------------------
module sfr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rx_valid_i,
  output logic          rx_ready_o,
  input  sfr_pkg::sts_t sts_i,
  output sfr_pkg::cmd_t cmd_o
);
  import sfr_pkg::*;

  typedef enum logic [3:0] {
    ST_HUNT_HI,
    ST_HUNT_LO,
    ST_SEED,
    ST_ID,
    ST_LEN,
    ST_DATA,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_EVENT,
    ST_READ,
    ST_SEND
  } state_e;

  state_e state_q, state_d;
  evt_e   evt_q, evt_d;
  logic   accept;

  always_comb begin
    case (state_q)
      ST_HUNT_HI, ST_HUNT_LO, ST_ID, ST_LEN,
      ST_DATA, ST_CRC_LO, ST_CRC_HI: rx_ready_o = 1'b1;
      default:                       rx_ready_o = 1'b0;
    endcase
  end

  assign accept = rx_valid_i && rx_ready_o;

  always_comb begin
    state_d = state_q;
    evt_d   = evt_q;
    cmd_o   = '{crc_op: CRC_HOLD, pos_op: POS_HOLD, out_op: OUT_NONE,
                evt_kind: evt_q, default: 1'b0};
    case (state_q)
      ST_HUNT_HI: begin
        if (accept && sts_i.hi_match) begin
          state_d = ST_HUNT_LO;
        end
      end
      ST_HUNT_LO: begin
        if (accept) begin
          if (sts_i.lo_match) begin
            cmd_o.crc_op    = CRC_SEED;
            cmd_o.hold_byte = 1'b1;
            cmd_o.clr_id    = 1'b1;
            cmd_o.pos_op    = POS_CLR;
            state_d         = ST_SEED;
          end else if (!sts_i.hi_match) begin
            // A sync loss before any id has been read reports id zero.
            cmd_o.clr_id   = 1'b1;
            cmd_o.inc_loss = 1'b1;
            evt_d          = EVT_SYNC_LOSS;
            state_d        = ST_EVENT;
          end
        end
      end
      ST_SEED: begin
        cmd_o.crc_op = CRC_HELD;
        state_d      = ST_ID;
      end
      ST_ID: begin
        if (accept) begin
          cmd_o.take_id = 1'b1;
          cmd_o.crc_op  = CRC_RX;
          state_d       = ST_LEN;
        end
      end
      ST_LEN: begin
        if (accept) begin
          if (sts_i.rx_len_bad) begin
            cmd_o.inc_loss = 1'b1;
            evt_d          = EVT_SYNC_LOSS;
            state_d        = ST_EVENT;
          end else begin
            cmd_o.take_len = 1'b1;
            cmd_o.crc_op   = CRC_RX;
            cmd_o.pos_op   = POS_CLR;
            state_d        = sts_i.rx_zero ? ST_CRC_LO : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (accept) begin
          cmd_o.wr_data = 1'b1;
          cmd_o.crc_op  = CRC_RX;
          if (sts_i.pos_last) begin
            cmd_o.pos_op = POS_CLR;
            state_d      = ST_CRC_LO;
          end else begin
            cmd_o.pos_op = POS_INC;
          end
        end
      end
      ST_CRC_LO: begin
        if (accept) begin
          cmd_o.take_crc_lo = 1'b1;
          state_d           = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        if (accept) begin
          cmd_o.pos_op = POS_CLR;
          if (!sts_i.crc_ok) begin
            cmd_o.inc_crc_err = 1'b1;
            evt_d             = EVT_CRC_ERR;
            state_d           = ST_EVENT;
          end else if (sts_i.len_zero) begin
            evt_d   = EVT_EMPTY;
            state_d = ST_EVENT;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_EVENT: begin
        if (sts_i.out_free) begin
          cmd_o.out_op = OUT_EVT;
          state_d      = ST_HUNT_HI;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_SEND;
      end
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.out_op = OUT_DATA;
          if (sts_i.pos_last) begin
            cmd_o.pos_op = POS_CLR;
            state_d      = ST_HUNT_HI;
          end else begin
            cmd_o.pos_op = POS_INC;
            state_d      = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_HUNT_HI;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT_HI;
      evt_q   <= EVT_SYNC_LOSS;
    end else begin
      state_q <= state_d;
      evt_q   <= evt_d;
    end
  end

endmodule
